>>> rtl/rgb16_to_led_frame_core_macros.svh
// Assertion macros shared by the frame encoder RTL.
`ifndef RGB16_TO_LED_FRAME_CORE_MACROS_SVH
`define RGB16_TO_LED_FRAME_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define R16LED_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define R16LED_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/r16led_pkg.sv
// Types, constants and helper functions for the RGB to LED frame encoder.
package r16led_pkg;

    localparam int CH_W      = 16;
    localparam int BR_W      = 5;
    localparam int BYTE_W    = 8;
    localparam int M31_W     = 21;
    localparam int SCALE_W   = 21;
    localparam int MID_W     = 19;
    localparam int RECIP_W   = 19;
    localparam int RECIP_SH  = 21;
    localparam int FRAME_W   = 32;

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_THREE = 2'd1,
        MODE_FINE  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        LVL_FULL = 2'd0,
        LVL_MID  = 2'd1,
        LVL_LOW  = 2'd2
    } level_t;

    localparam logic [CH_W-1:0]    LVL_HIGH_TH = 16'd10570;
    localparam logic [CH_W-1:0]    LVL_MID_TH  = 16'd2114;
    localparam logic [BR_W-1:0]    BR_FULL     = 5'd31;
    localparam logic [BR_W-1:0]    BR_MID      = 5'd5;
    localparam logic [BR_W-1:0]    BR_LOW      = 5'd1;
    localparam logic [2:0]         FRAME_MARK  = 3'b111;
    // ceil(2^21 / 5); exact floor division by 5 for any 19-bit value.
    localparam logic [RECIP_W-1:0] RECIP5      = 19'd419431;

    typedef struct packed {
        mode_t           mode;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        mode_t            mode;
        level_t           level;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [M31_W-1:0] max31;
        logic [M31_W-1:0] red31;
        logic [M31_W-1:0] green31;
        logic [M31_W-1:0] blue31;
    } front_t;

    typedef struct packed {
        logic               fine;
        logic [BR_W-1:0]    bright;
        logic [BYTE_W-1:0]  red_byte;
        logic [BYTE_W-1:0]  green_byte;
        logic [BYTE_W-1:0]  blue_byte;
        logic [SCALE_W-1:0] scale;
        logic [CH_W-1:0]    red;
        logic [CH_W-1:0]    green;
        logic [CH_W-1:0]    blue;
    } scaled_t;

    function automatic logic [M31_W-1:0] times31(input logic [CH_W-1:0] c);
        return {c, 5'b00000} - {5'b00000, c};
    endfunction

    // floor(0x1F0000 / br); zero brightness only occurs for a black pixel.
    function automatic logic [SCALE_W-1:0] fine_scale(input logic [BR_W-1:0] br);
        logic [SCALE_W-1:0] s;
        case (br)
            5'd1:    s = 21'd2031616;
            5'd2:    s = 21'd1015808;
            5'd3:    s = 21'd677205;
            5'd4:    s = 21'd507904;
            5'd5:    s = 21'd406323;
            5'd6:    s = 21'd338602;
            5'd7:    s = 21'd290230;
            5'd8:    s = 21'd253952;
            5'd9:    s = 21'd225735;
            5'd10:   s = 21'd203161;
            5'd11:   s = 21'd184692;
            5'd12:   s = 21'd169301;
            5'd13:   s = 21'd156278;
            5'd14:   s = 21'd145115;
            5'd15:   s = 21'd135441;
            5'd16:   s = 21'd126976;
            5'd17:   s = 21'd119506;
            5'd18:   s = 21'd112867;
            5'd19:   s = 21'd106927;
            5'd20:   s = 21'd101580;
            5'd21:   s = 21'd96743;
            5'd22:   s = 21'd92346;
            5'd23:   s = 21'd88331;
            5'd24:   s = 21'd84650;
            5'd25:   s = 21'd81264;
            5'd26:   s = 21'd78139;
            5'd27:   s = 21'd75245;
            5'd28:   s = 21'd72557;
            5'd29:   s = 21'd70055;
            5'd30:   s = 21'd67720;
            5'd31:   s = 21'd65536;
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/r16led_ifs.sv
// Valid/ready channel interfaces for pixel input and frame word output.
interface r16led_pixel_if;
    logic        valid;
    logic        ready;
    logic [15:0] red_level;
    logic [15:0] green_level;
    logic [15:0] blue_level;

    modport source (output valid, output red_level, output green_level,
                    output blue_level, input ready);
    modport sink (input valid, input red_level, input green_level,
                  input blue_level, output ready);
endinterface

interface r16led_frame_if;
    logic        valid;
    logic        ready;
    logic [31:0] frame_word;

    modport source (output valid, output frame_word, input ready);
    modport sink (input valid, input frame_word, output ready);
endinterface

>>> rtl/r16led_front.sv
// First stage: channel OR, level class and times-31 products.
module r16led_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  r16led_pkg::pixel_t  up_data,
    output logic                dn_valid,
    input  logic                dn_ready,
    output r16led_pkg::front_t  dn_data
);

    logic                           valid_reg;
    logic                           valid_next;
    r16led_pkg::front_t             data_reg;
    r16led_pkg::front_t             data_next;
    logic [r16led_pkg::CH_W-1:0]    max_any;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    // The OR of the channels bounds the largest channel from above.
    assign max_any = up_data.red | up_data.green | up_data.blue;

    always_comb
    begin
        data_next.mode    = up_data.mode;
        data_next.red     = up_data.red;
        data_next.green   = up_data.green;
        data_next.blue    = up_data.blue;
        data_next.max31   = r16led_pkg::times31(max_any);
        data_next.red31   = r16led_pkg::times31(up_data.red);
        data_next.green31 = r16led_pkg::times31(up_data.green);
        data_next.blue31  = r16led_pkg::times31(up_data.blue);
        if (max_any >= r16led_pkg::LVL_HIGH_TH)
        begin
            data_next.level = r16led_pkg::LVL_FULL;
        end
        else if (max_any >= r16led_pkg::LVL_MID_TH)
        begin
            data_next.level = r16led_pkg::LVL_MID;
        end
        else
        begin
            data_next.level = r16led_pkg::LVL_LOW;
        end
    end

    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

>>> rtl/r16led_scale.sv
// Second stage: brightness choice, divide by five and fine scale lookup.
module r16led_scale (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  r16led_pkg::front_t  up_data,
    output logic                dn_valid,
    input  logic                dn_ready,
    output r16led_pkg::scaled_t dn_data
);

    localparam int PROD_W = r16led_pkg::MID_W + r16led_pkg::RECIP_W;
    localparam int BYTE_LO = r16led_pkg::RECIP_SH + 8;
    localparam int BYTE_HI = r16led_pkg::RECIP_SH + 15;

    logic                            valid_reg;
    logic                            valid_next;
    r16led_pkg::scaled_t             data_reg;
    r16led_pkg::scaled_t             data_next;
    logic [r16led_pkg::BR_W-1:0]     hi_part;
    logic [r16led_pkg::CH_W-1:0]     lo_part;
    logic [r16led_pkg::CH_W:0]       part_sum;
    logic [r16led_pkg::BR_W-1:0]     round_up;
    logic [r16led_pkg::BR_W-1:0]     fine_br;
    logic [PROD_W-1:0]               red_div;
    logic [PROD_W-1:0]               green_div;
    logic [PROD_W-1:0]               blue_div;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    // ceil(t / 65535) with t = hi*65536 + lo = hi*65535 + (hi + lo).
    assign hi_part  = up_data.max31[r16led_pkg::M31_W-1:r16led_pkg::CH_W];
    assign lo_part  = up_data.max31[r16led_pkg::CH_W-1:0];
    assign part_sum = {1'b0, lo_part} + {12'd0, hi_part};

    always_comb
    begin
        if (part_sum == 17'd0)
        begin
            round_up = 5'd0;
        end
        else if (part_sum > 17'd65535)
        begin
            round_up = 5'd2;
        end
        else
        begin
            round_up = 5'd1;
        end
    end

    assign fine_br = hi_part + round_up;

    // floor(c*31/5) through the reciprocal; valid because c*31 fits 19 bits here.
    assign red_div   = {{r16led_pkg::RECIP_W{1'b0}}, up_data.red31[r16led_pkg::MID_W-1:0]}
                     * {{r16led_pkg::MID_W{1'b0}}, r16led_pkg::RECIP5};
    assign green_div = {{r16led_pkg::RECIP_W{1'b0}}, up_data.green31[r16led_pkg::MID_W-1:0]}
                     * {{r16led_pkg::MID_W{1'b0}}, r16led_pkg::RECIP5};
    assign blue_div  = {{r16led_pkg::RECIP_W{1'b0}}, up_data.blue31[r16led_pkg::MID_W-1:0]}
                     * {{r16led_pkg::MID_W{1'b0}}, r16led_pkg::RECIP5};

    always_comb
    begin
        data_next.fine       = 1'b0;
        data_next.bright     = r16led_pkg::BR_FULL;
        data_next.red_byte   = up_data.red[15:8];
        data_next.green_byte = up_data.green[15:8];
        data_next.blue_byte  = up_data.blue[15:8];
        data_next.scale      = r16led_pkg::fine_scale(fine_br);
        data_next.red        = up_data.red;
        data_next.green      = up_data.green;
        data_next.blue       = up_data.blue;
        case (up_data.mode)
            r16led_pkg::MODE_THREE:
            begin
                case (up_data.level)
                    r16led_pkg::LVL_MID:
                    begin
                        data_next.bright     = r16led_pkg::BR_MID;
                        data_next.red_byte   = red_div[BYTE_HI:BYTE_LO];
                        data_next.green_byte = green_div[BYTE_HI:BYTE_LO];
                        data_next.blue_byte  = blue_div[BYTE_HI:BYTE_LO];
                    end
                    r16led_pkg::LVL_LOW:
                    begin
                        data_next.bright     = r16led_pkg::BR_LOW;
                        data_next.red_byte   = up_data.red31[15:8];
                        data_next.green_byte = up_data.green31[15:8];
                        data_next.blue_byte  = up_data.blue31[15:8];
                    end
                    default:
                    begin
                        data_next.bright = r16led_pkg::BR_FULL;
                    end
                endcase
            end
            r16led_pkg::MODE_FINE:
            begin
                data_next.fine   = 1'b1;
                data_next.bright = fine_br;
            end
            default:
            begin
                data_next.fine = 1'b0;
            end
        endcase
    end

    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

>>> rtl/r16led_pack.sv
// Third stage: fine-mode channel products and frame word assembly.
module r16led_pack (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  r16led_pkg::scaled_t  up_data,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output logic [31:0]          dn_word
);

    localparam int PROD_W = r16led_pkg::CH_W + r16led_pkg::SCALE_W;

    logic                                 valid_reg;
    logic                                 valid_next;
    logic [r16led_pkg::FRAME_W-1:0]       word_reg;
    logic [r16led_pkg::FRAME_W-1:0]       word_next;
    logic [PROD_W-1:0]                    red_prod;
    logic [PROD_W-1:0]                    green_prod;
    logic [PROD_W-1:0]                    blue_prod;
    logic [r16led_pkg::BYTE_W-1:0]        red_b;
    logic [r16led_pkg::BYTE_W-1:0]        green_b;
    logic [r16led_pkg::BYTE_W-1:0]        blue_b;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

    assign red_prod   = {{r16led_pkg::SCALE_W{1'b0}}, up_data.red}
                      * {{r16led_pkg::CH_W{1'b0}}, up_data.scale};
    assign green_prod = {{r16led_pkg::SCALE_W{1'b0}}, up_data.green}
                      * {{r16led_pkg::CH_W{1'b0}}, up_data.scale};
    assign blue_prod  = {{r16led_pkg::SCALE_W{1'b0}}, up_data.blue}
                      * {{r16led_pkg::CH_W{1'b0}}, up_data.scale};

    // A black pixel has zero scale, so fine mode gives empty color bytes.
    assign red_b   = up_data.fine ? red_prod[31:24]   : up_data.red_byte;
    assign green_b = up_data.fine ? green_prod[31:24] : up_data.green_byte;
    assign blue_b  = up_data.fine ? blue_prod[31:24]  : up_data.blue_byte;

    assign word_next = {r16led_pkg::FRAME_MARK, up_data.bright, blue_b, green_b, red_b};

    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            word_reg <= word_next;
        end
    end

endmodule

>>> rtl/rgb16_to_led_frame_core.sv
// An accepted pixel word passes through the front, scale and pack stage registers to the frame channel.
// Throughput: one pixel per cycle while the frame channel is ready; three register stages, each with its own valid bit.
// A stage takes a new word whenever it is empty or its successor takes its word.
// Reset clears all stage valid bits and sets the encode mode to three-level.
// Top level of the RGB pixel to LED frame word encoder.
`include "rgb16_to_led_frame_core_macros.svh"

module rgb16_to_led_frame_core (
    input  logic                  clk,
    input  logic                  rst_n,
    r16led_pixel_if.sink          pixel,
    r16led_frame_if.source        frame,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_wdata
);

    r16led_pkg::mode_t    mode_reg;
    r16led_pkg::mode_t    mode_next;
    r16led_pkg::pixel_t   in_data;
    logic                 s1_valid;
    logic                 s1_ready;
    r16led_pkg::front_t   s1_data;
    logic                 s2_valid;
    logic                 s2_ready;
    r16led_pkg::scaled_t  s2_data;

    assign mode_next = cfg_we ? r16led_pkg::mode_t'(cfg_wdata) : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= r16led_pkg::MODE_THREE;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    assign in_data.mode  = mode_reg;
    assign in_data.red   = pixel.red_level;
    assign in_data.green = pixel.green_level;
    assign in_data.blue  = pixel.blue_level;

    r16led_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (pixel.valid),
        .up_ready (pixel.ready),
        .up_data  (in_data),
        .dn_valid (s1_valid),
        .dn_ready (s1_ready),
        .dn_data  (s1_data)
    );

    r16led_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_ready (s1_ready),
        .up_data  (s1_data),
        .dn_valid (s2_valid),
        .dn_ready (s2_ready),
        .dn_data  (s2_data)
    );

    r16led_pack u_pack (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s2_valid),
        .up_ready (s2_ready),
        .up_data  (s2_data),
        .dn_valid (frame.valid),
        .dn_ready (frame.ready),
        .dn_word  (frame.frame_word)
    );

    `R16LED_ASSERT_NOW(a_marker_bits, frame.valid, frame.frame_word[31:29] == 3'b111, "frame word lost its marker bits")
    `R16LED_ASSERT_NOW(a_zero_bright_black, s2_valid && s2_data.fine && (s2_data.bright == 5'd0), (s2_data.red | s2_data.green | s2_data.blue) == 16'd0, "zero fine brightness on a lit pixel")
    `R16LED_ASSERT_NEXT(a_mode_write, cfg_we, mode_reg == $past(cfg_wdata), "mode register missed a write")
    `R16LED_ASSERT_NOW(a_empty_takes, !s1_valid, pixel.ready, "empty first stage refused a word")

endmodule
